@@ hw/rtl/slfd_pkg.sv @@
// Package with the shared constants and types of the sync and length framed deframer.
`timescale 1ns / 1ps

package slfd_pkg;

    localparam int MAX_FRAME   = 128;
    localparam int HDR_LEN     = 8;
    localparam int ANGLE_MIN   = 14;
    localparam int CHECK_LEN   = 4;
    localparam int STORE_DEPTH = 20;

    localparam int FILL_W  = 8;
    localparam int INDEX_W = $clog2(STORE_DEPTH);
    localparam int CMP_W   = 16;

    localparam logic [7:0] SYNC_BYTE = 8'hA5;

    localparam logic [FILL_W-1:0] FILL_MAX   = FILL_W'(MAX_FRAME);
    localparam logic [FILL_W-1:0] FILL_STORE = FILL_W'(STORE_DEPTH);
    localparam logic [FILL_W-1:0] FILL_CHECK = FILL_W'(CHECK_LEN);
    localparam logic [FILL_W-1:0] FILL_HDR   = FILL_W'(HDR_LEN);

    localparam logic [CMP_W-1:0] PAYLOAD_MAX = CMP_W'(MAX_FRAME - HDR_LEN);
    localparam logic [CMP_W-1:0] ANGLE_LEN   = CMP_W'(ANGLE_MIN);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SYNC = 5'b00010,
        S_LEN  = 5'b00100,
        S_FILL = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

endpackage

@@ hw/rtl/sync_length_frame_deframer_top.sv @@
// Top level of the sync and length framed deframer with its compare sequencer.
// A frame-completing byte passes S_SYNC, S_LEN, S_FILL and S_OUT before its result
// is registered; bytes are taken only in S_IDLE. One shared 16-bit compare unit
// checks sync byte, length bound, fill level and angle length in turn, one per cycle.
// A result waiting under stall holds the sequencer before the output register.
// Reset is synchronous and active low; it empties the buffer and clears output valid.
`timescale 1ns / 1ps

module sync_length_frame_deframer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_command_id,
    output logic [15:0] o_flag_word,
    output logic [6:0]  o_payload_length,
    output logic        o_angles_present,
    output logic [31:0] o_yaw_bits,
    output logic [31:0] o_pitch_bits
);

    slfd_pkg::t_state r_state, n_state;
    logic [slfd_pkg::FILL_W-1:0] r_fill, n_fill;
    logic [7:0] r_frame [slfd_pkg::STORE_DEPTH];

    logic r_out_valid, n_out_valid;
    logic [15:0] r_command_id;
    logic [15:0] r_flag_word;
    logic [6:0]  r_payload_length;
    logic        r_angles_present;
    logic [31:0] r_yaw_bits;
    logic [31:0] r_pitch_bits;

    logic [slfd_pkg::CMP_W-1:0] u_a, u_b;
    logic [slfd_pkg::CMP_W:0]   u_diff;
    logic u_lt, u_eq;

    logic [15:0] w_payload;
    logic [slfd_pkg::FILL_W-1:0] w_total;
    logic w_accept, w_store, w_drop, w_load;

    assign w_payload = {r_frame[2], r_frame[1]};
    assign w_total   = w_payload[slfd_pkg::FILL_W-1:0] + slfd_pkg::FILL_HDR;
    assign w_accept  = i_in_valid && !o_in_stall;
    assign w_store   = w_accept && (r_fill < slfd_pkg::FILL_STORE);

    always_comb begin
        case (r_state)
            slfd_pkg::S_SYNC: begin
                u_a = {8'h00, r_frame[0]};
                u_b = {8'h00, slfd_pkg::SYNC_BYTE};
            end
            slfd_pkg::S_LEN: begin
                u_a = w_payload;
                u_b = slfd_pkg::PAYLOAD_MAX;
            end
            slfd_pkg::S_FILL: begin
                u_a = {8'h00, r_fill};
                u_b = {8'h00, w_total};
            end
            default: begin
                u_a = w_payload;
                u_b = slfd_pkg::ANGLE_LEN;
            end
        endcase
    end

    assign u_diff = {1'b0, u_a} - {1'b0, u_b};
    assign u_lt   = u_diff[slfd_pkg::CMP_W];
    assign u_eq   = (u_diff == '0);

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_out_valid = r_out_valid && i_out_stall;
        w_drop      = 1'b0;
        w_load      = 1'b0;
        case (r_state)
            slfd_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (r_fill < slfd_pkg::FILL_MAX) begin
                        n_fill = r_fill + 1'b1;
                    end
                    n_state = slfd_pkg::S_SYNC;
                end
            end
            slfd_pkg::S_SYNC: begin
                if (r_fill < slfd_pkg::FILL_CHECK) begin
                    n_state = slfd_pkg::S_IDLE;
                end else if (!u_eq) begin
                    w_drop  = 1'b1;
                    n_fill  = r_fill - 1'b1;
                    n_state = slfd_pkg::S_IDLE;
                end else begin
                    n_state = slfd_pkg::S_LEN;
                end
            end
            slfd_pkg::S_LEN: begin
                if (!u_lt && !u_eq) begin
                    w_drop  = 1'b1;
                    n_fill  = r_fill - 1'b1;
                    n_state = slfd_pkg::S_IDLE;
                end else begin
                    n_state = slfd_pkg::S_FILL;
                end
            end
            slfd_pkg::S_FILL: begin
                if (u_lt) begin
                    n_state = slfd_pkg::S_IDLE;
                end else begin
                    n_state = slfd_pkg::S_OUT;
                end
            end
            slfd_pkg::S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_load      = 1'b1;
                    n_out_valid = 1'b1;
                    n_fill      = '0;
                    n_state     = slfd_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = slfd_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= slfd_pkg::S_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_frame[r_fill[slfd_pkg::INDEX_W-1:0]] <= i_rx_byte;
        end
        if (w_drop) begin
            r_frame[0] <= r_frame[1];
            r_frame[1] <= r_frame[2];
            r_frame[2] <= r_frame[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_command_id     <= {r_frame[5], r_frame[4]};
            r_flag_word      <= {r_frame[7], r_frame[6]};
            r_payload_length <= w_payload[6:0];
            r_angles_present <= !u_lt;
            if (!u_lt) begin
                r_yaw_bits   <= {r_frame[11], r_frame[10], r_frame[9], r_frame[8]};
                r_pitch_bits <= {r_frame[15], r_frame[14], r_frame[13], r_frame[12]};
            end else begin
                r_yaw_bits   <= '0;
                r_pitch_bits <= '0;
            end
        end
    end

    assign o_in_stall       = (r_state != slfd_pkg::S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_command_id     = r_command_id;
    assign o_flag_word      = r_flag_word;
    assign o_payload_length = r_payload_length;
    assign o_angles_present = r_angles_present;
    assign o_yaw_bits       = r_yaw_bits;
    assign o_pitch_bits     = r_pitch_bits;

    a_stall_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_in_stall)
        else $error("Input beat was not followed by a busy cycle.");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= slfd_pkg::FILL_MAX)
        else $error("Buffer fill level exceeds the largest frame.");

    a_load_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (r_fill == '0) && o_out_valid)
        else $error("Completed frame did not empty the buffer and raise valid.");

    a_angles_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_angles_present == (o_payload_length >= 7'(slfd_pkg::ANGLE_MIN))))
        else $error("Angle flag disagrees with the payload length.");

endmodule
